// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication violated");

`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)

`define ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

// ===== rtl/core/bme_pkg.sv =====
package bme_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ANG_W        = 33;
  localparam int QUO_W        = 24;
  localparam int REM_W        = 32;
  localparam int RATE_W       = 37;
  localparam int TAN_W        = 26;
  localparam int TS_W         = 17;
  localparam int IWB_W        = 20;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_BASE = 2'd1;

  localparam logic [TS_W-1:0]  TIME_STEP_RST = 17'd655;
  localparam logic [IWB_W-1:0] IWB_RST       = 20'd26214;

  localparam logic [29:0] PHASE_SCALE = 30'd683565276;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [TAN_W-1:0] TAN_LIMIT   = 26'sd16777216;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768
  };

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] c;
    logic signed [ANG_W-1:0] s;
  } sincos_t;

  typedef struct packed {
    logic                     valid;
    quad_t                    quad_h;
    quad_t                    quad_s;
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic signed [31:0]       hd;
    logic signed [31:0]       sp;
    logic signed [RATE_W-1:0] rate;
    logic signed [31:0]       spd_new;
  } side1_t;

  typedef struct packed {
    logic                     valid;
    logic                     neg;
    logic                     sat;
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic signed [31:0]       hd;
    logic signed [31:0]       sp;
    logic signed [RATE_W-1:0] rate;
    logic signed [31:0]       spd_new;
    logic signed [ANG_W-1:0]  cos_h;
    logic signed [ANG_W-1:0]  sin_h;
  } side2_t;

  function automatic sincos_t quad_rotate(input quad_t q,
                                          input logic signed [ANG_W-1:0] x,
                                          input logic signed [ANG_W-1:0] y);
    sincos_t r;
    unique case (q)
      QUAD_0: begin r.c = x;  r.s = y;  end
      QUAD_1: begin r.c = -y; r.s = x;  end
      QUAD_2: begin r.c = -x; r.s = -y; end
      QUAD_3: begin r.c = y;  r.s = -x; end
    endcase
    return r;
  endfunction

  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                  input logic [5:0] s);
    logic signed [65:0] half;
    half = 66'sd1 <<< (s - 6'd1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bicycle_model_euler_step_unit.sv =====
// One forward-Euler step of the kinematic bicycle model in signed Q16.16.
// A fully pipelined datapath takes one beat per clock unless the output stalls
// and returns its result through two phase multiply stages, a row of 16
// CORDIC cells for heading and steering, a quadrant stage, a row of 24 divider
// cells for the steering tangent, three multiply/round stages and the output
// register. The whole row holds while a result sits unaccepted on the output.
// Configuration (index 0 time_step, index 1 inv_wheel_base) is always ready.
`include "assert_macros.svh"

module bicycle_model_euler_step_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic signed [31:0]                  heading,
  input  logic signed [31:0]                  speed,
  input  logic signed [17:0]                  steer_angle,
  input  logic signed [31:0]                  accel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  new_pos_x,
  output logic signed [31:0]                  new_pos_y,
  output logic signed [31:0]                  new_heading,
  output logic signed [31:0]                  new_speed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bme_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bme_pkg::*;

  logic [TS_W-1:0]    time_step;
  logic [IWB_W-1:0]   inv_wheel_base;
  logic               en;
  logic signed [TS_W:0] dt_s;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign dt_s      = $signed({1'b0, time_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= TIME_STEP_RST;
      inv_wheel_base <= IWB_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIME_STEP:      time_step      <= cfg_data[TS_W-1:0];
        CFG_INV_WHEEL_BASE: inv_wheel_base <= cfg_data[IWB_W-1:0];
        default: ;
      endcase
    end
  end

  // stage A
  logic signed [31:0] st32;
  logic signed [62:0] ph_h_prod, ph_s_prod;
  logic signed [52:0] rate_prod;
  logic signed [49:0] dv_prod;
  logic               a_valid;
  logic [31:0]        a_ph_h, a_ph_s;
  logic signed [52:0] a_rate_p;
  logic signed [49:0] a_dv;
  logic signed [31:0] a_px, a_py, a_hd, a_sp;

  assign st32      = $signed({{14{steer_angle[17]}}, steer_angle});
  assign ph_h_prod = heading * $signed({1'b0, PHASE_SCALE});
  assign ph_s_prod = st32 * $signed({1'b0, PHASE_SCALE});
  assign rate_prod = speed * $signed({1'b0, inv_wheel_base});
  assign dv_prod   = accel * dt_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_ph_h   <= ph_h_prod[47:16];
      a_ph_s   <= ph_s_prod[47:16];
      a_rate_p <= rate_prod;
      a_dv     <= dv_prod;
      a_px     <= pos_x;
      a_py     <= pos_y;
      a_hd     <= heading;
      a_sp     <= speed;
    end
  end

  // stage B
  logic [61:0]             zp_h, zp_s;
  logic signed [65:0]      rate_r;
  side1_t                  b_next;
  side1_t                  side1 [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] b_z_h, b_z_s;

  assign zp_h = a_ph_h[29:0] * PI_Q30;
  assign zp_s = a_ph_s[29:0] * PI_Q30;

  always_comb begin
    rate_r          = rnd_shr(66'(a_rate_p), 6'd16);
    b_next.valid    = a_valid;
    b_next.quad_h   = quad_t'(a_ph_h[31:30]);
    b_next.quad_s   = quad_t'(a_ph_s[31:30]);
    b_next.px       = a_px;
    b_next.py       = a_py;
    b_next.hd       = a_hd;
    b_next.sp       = a_sp;
    b_next.rate     = rate_r[RATE_W-1:0];
    b_next.spd_new  = sat32(66'(a_sp) + rnd_shr(66'(a_dv), 6'd16));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) side1[k].valid <= 1'b0;
    end else if (en) begin
      side1[0] <= b_next;
      for (int k = 1; k <= CORDIC_STEPS; k++) side1[k] <= side1[k-1];
    end
    if (en) begin
      b_z_h <= $signed({2'b00, zp_h[61:31]});
      b_z_s <= $signed({2'b00, zp_s[61:31]});
    end
  end

  // CORDIC rows
  logic signed [ANG_W-1:0] hx [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] hy [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] hz [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] sx [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] sy [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] sz [0:CORDIC_STEPS];

  assign hx[0] = CORDIC_GAIN;
  assign hy[0] = '0;
  assign hz[0] = b_z_h;
  assign sx[0] = CORDIC_GAIN;
  assign sy[0] = '0;
  assign sz[0] = b_z_s;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    bme_cordic_cell u_head (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(k)),
      .x_in (hx[k]),
      .y_in (hy[k]),
      .z_in (hz[k]),
      .x    (hx[k+1]),
      .y    (hy[k+1]),
      .z    (hz[k+1])
    );
    bme_cordic_cell u_steer (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(k)),
      .x_in (sx[k]),
      .y_in (sy[k]),
      .z_in (sz[k]),
      .x    (sx[k+1]),
      .y    (sy[k+1]),
      .z    (sz[k+1])
    );
  end

  // stage C
  sincos_t                 rot_h, rot_s;
  logic signed [ANG_W-1:0] as_v, ac_v;
  side2_t                  c_next;
  side2_t                  side2 [0:QUO_W];
  logic [REM_W-1:0]        c_rem, c_dvs;
  logic [QUO_W-1:0]        c_num;

  always_comb begin
    rot_h          = quad_rotate(side1[CORDIC_STEPS].quad_h, hx[CORDIC_STEPS],
                                 hy[CORDIC_STEPS]);
    rot_s          = quad_rotate(side1[CORDIC_STEPS].quad_s, sx[CORDIC_STEPS],
                                 sy[CORDIC_STEPS]);
    as_v           = rot_s.s[ANG_W-1] ? -rot_s.s : rot_s.s;
    ac_v           = rot_s.c[ANG_W-1] ? -rot_s.c : rot_s.c;
    c_next.valid   = side1[CORDIC_STEPS].valid;
    c_next.neg     = rot_s.s[ANG_W-1] ^ rot_s.c[ANG_W-1];
    c_next.sat     = {8'b0, as_v[31:0]} >= {ac_v[31:0], 8'b0};
    c_next.px      = side1[CORDIC_STEPS].px;
    c_next.py      = side1[CORDIC_STEPS].py;
    c_next.hd      = side1[CORDIC_STEPS].hd;
    c_next.sp      = side1[CORDIC_STEPS].sp;
    c_next.rate    = side1[CORDIC_STEPS].rate;
    c_next.spd_new = side1[CORDIC_STEPS].spd_new;
    c_next.cos_h   = rot_h.c;
    c_next.sin_h   = rot_h.s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) side2[k].valid <= 1'b0;
    end else if (en) begin
      side2[0] <= c_next;
      for (int k = 1; k <= QUO_W; k++) side2[k] <= side2[k-1];
    end
    if (en) begin
      c_rem <= {8'b0, as_v[31:8]};
      c_num <= {as_v[7:0], 16'b0};
      c_dvs <= ac_v[31:0];
    end
  end

  // divider row
  logic [REM_W-1:0] rem_a [0:QUO_W];
  logic [QUO_W-1:0] num_a [0:QUO_W];
  logic [QUO_W-1:0] quo_a [0:QUO_W];
  logic [REM_W-1:0] dvs_a [0:QUO_W];

  assign rem_a[0] = c_rem;
  assign num_a[0] = c_num;
  assign quo_a[0] = '0;
  assign dvs_a[0] = c_dvs;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    bme_div_cell u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (rem_a[k]),
      .num_in (num_a[k]),
      .quo_in (quo_a[k]),
      .dvs_in (dvs_a[k]),
      .rem    (rem_a[k+1]),
      .num    (num_a[k+1]),
      .quo    (quo_a[k+1]),
      .dvs    (dvs_a[k+1])
    );
  end

  // tail stage 1
  logic signed [TAN_W-1:0]  tmag, tn;
  logic signed [64:0]       mx, my;
  logic                     t1_valid;
  logic signed [31:0]       t1_px, t1_py, t1_hd, t1_spd;
  logic signed [64:0]       t1_mx, t1_my;
  logic signed [RATE_W-1:0] t1_rate;
  logic signed [TAN_W-1:0]  t1_tn;

  always_comb begin
    tmag = side2[QUO_W].sat ? TAN_LIMIT : $signed({2'b00, quo_a[QUO_W]});
    tn   = side2[QUO_W].neg ? -tmag : tmag;
    mx   = side2[QUO_W].sp * side2[QUO_W].cos_h;
    my   = side2[QUO_W].sp * side2[QUO_W].sin_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (en) begin
      t1_valid <= side2[QUO_W].valid;
    end
    if (en) begin
      t1_px   <= side2[QUO_W].px;
      t1_py   <= side2[QUO_W].py;
      t1_hd   <= side2[QUO_W].hd;
      t1_spd  <= side2[QUO_W].spd_new;
      t1_mx   <= mx;
      t1_my   <= my;
      t1_rate <= side2[QUO_W].rate;
      t1_tn   <= tn;
    end
  end

  // tail stage 2
  logic signed [65:0] dx, dy;
  logic signed [53:0] dxt, dyt;
  logic signed [62:0] ydp;
  logic               t2_valid;
  logic signed [31:0] t2_px, t2_py, t2_hd, t2_spd;
  logic signed [53:0] t2_dxt, t2_dyt;
  logic signed [62:0] t2_ydp;

  always_comb begin
    dx  = rnd_shr(66'(t1_mx), 6'd30);
    dy  = rnd_shr(66'(t1_my), 6'd30);
    dxt = 36'(dx) * dt_s;
    dyt = 36'(dy) * dt_s;
    ydp = t1_rate * t1_tn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else if (en) begin
      t2_valid <= t1_valid;
    end
    if (en) begin
      t2_px  <= t1_px;
      t2_py  <= t1_py;
      t2_hd  <= t1_hd;
      t2_spd <= t1_spd;
      t2_dxt <= dxt;
      t2_dyt <= dyt;
      t2_ydp <= ydp;
    end
  end

  // tail stage 3
  logic signed [65:0] yawd;
  logic signed [64:0] yawt;
  logic               t3_valid;
  logic signed [31:0] t3_x, t3_y, t3_hd, t3_spd;
  logic signed [64:0] t3_yawt;

  always_comb begin
    yawd = rnd_shr(66'(t2_ydp), 6'd16);
    yawt = 47'(yawd) * dt_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_valid <= 1'b0;
    end else if (en) begin
      t3_valid <= t2_valid;
    end
    if (en) begin
      t3_x    <= sat32(66'(t2_px) + rnd_shr(66'(t2_dxt), 6'd16));
      t3_y    <= sat32(66'(t2_py) + rnd_shr(66'(t2_dyt), 6'd16));
      t3_hd   <= t2_hd;
      t3_spd  <= t2_spd;
      t3_yawt <= yawt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= t3_valid;
    end
    if (en) begin
      new_pos_x   <= t3_x;
      new_pos_y   <= t3_y;
      new_heading <= sat32(66'(t3_hd) + rnd_shr(66'(t3_yawt), 6'd16));
      new_speed   <= t3_spd;
    end
  end

  logic hz_conv, sz_conv;

  assign hz_conv = (hz[CORDIC_STEPS] < 33'sd65536) && (hz[CORDIC_STEPS] > -33'sd65536);
  assign sz_conv = (sz[CORDIC_STEPS] < 33'sd65536) && (sz[CORDIC_STEPS] > -33'sd65536);

  `ASSERT_IMPLIES(a_div_range, clk, rst, side2[0].valid, side2[0].sat || (c_rem < c_dvs))
  `ASSERT_IMPLIES(a_zero_cos_sat, clk, rst, side2[0].valid && (c_dvs == '0), side2[0].sat)
  `ASSERT_IMPLIES(a_cordic_conv, clk, rst, side1[CORDIC_STEPS].valid, hz_conv && sz_conv)
  `ASSERT_NEXT(a_hold_stage_a, clk, rst, out_valid && out_stall && a_valid, a_valid)

endmodule

// ===== rtl/core/bme_cordic_cell.sv =====
module bme_cordic_cell (
  input  logic                                clk,
  input  logic                                en,
  input  logic [bme_pkg::STEP_W-1:0]          step,
  input  logic signed [bme_pkg::ANG_W-1:0]    x_in,
  input  logic signed [bme_pkg::ANG_W-1:0]    y_in,
  input  logic signed [bme_pkg::ANG_W-1:0]    z_in,
  output logic signed [bme_pkg::ANG_W-1:0]    x,
  output logic signed [bme_pkg::ANG_W-1:0]    y,
  output logic signed [bme_pkg::ANG_W-1:0]    z
);
  import bme_pkg::*;

  logic signed [ANG_W-1:0] xs, ys, ang, x_next, y_next, z_next;

  always_comb begin
    xs  = x_in >>> step;
    ys  = y_in >>> step;
    ang = $signed({1'b0, ATAN_Q30[step]});
    if (z_in[ANG_W-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ang;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

// ===== rtl/core/bme_div_cell.sv =====
module bme_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bme_pkg::REM_W-1:0]     rem_in,
  input  logic [bme_pkg::QUO_W-1:0]     num_in,
  input  logic [bme_pkg::QUO_W-1:0]     quo_in,
  input  logic [bme_pkg::REM_W-1:0]     dvs_in,
  output logic [bme_pkg::REM_W-1:0]     rem,
  output logic [bme_pkg::QUO_W-1:0]     num,
  output logic [bme_pkg::QUO_W-1:0]     quo,
  output logic [bme_pkg::REM_W-1:0]     dvs
);
  import bme_pkg::*;

  logic [REM_W:0]   trial, diff;
  logic             ge;
  logic [REM_W-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, num_in[QUO_W-1]};
    diff     = trial - {1'b0, dvs_in};
    ge       = trial >= {1'b0, dvs_in};
    rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      num <= {num_in[QUO_W-2:0], 1'b0};
      quo <= {quo_in[QUO_W-2:0], ge};
      dvs <= dvs_in;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bme_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD = 700;
  localparam int DRAIN_CYCLES = 80;
  localparam longint STEER_MAX = 102944;

  typedef struct {
    logic signed [31:0] px, py, hd, sp;
    logic signed [17:0] st;
    logic signed [31:0] ac;
  } vstate_t;

  typedef struct {
    logic signed [31:0] px, py, hd, sp;
  } vnext_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, heading = '0, speed = '0, accel = '0;
  logic signed [17:0] steer_angle = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] new_pos_x, new_pos_y, new_heading, new_speed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [TS_W-1:0] dt_q = TIME_STEP_RST;
  logic [IWB_W-1:0] iwb_q = IWB_RST;
  vnext_t next_state_q[$];
  int errors = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  bicycle_model_euler_step_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint round_shr(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sin_cos(longint ang, output longint c, output longint s);
    logic [63:0] prod;
    logic [29:0] r;
    quad_t q;
    longint x, y, z, xs, ys;
    prod = 64'(ang) * 64'(PHASE_SCALE);
    q = quad_t'(prod[47:46]);
    r = prod[45:16];
    z = longint'((64'(r) * 64'(PI_Q30)) >> 31);
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
      end
    end
    case (q)
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint steer_tan(longint ang);
    longint c, s, ac, as, q;
    bit neg;
    sin_cos(ang, c, s);
    neg = (s < 0) != (c < 0);
    ac = (c < 0) ? -c : c;
    as = (s < 0) ? -s : s;
    if (as * 65536 >= longint'(TAN_LIMIT) * ac) q = longint'(TAN_LIMIT);
    else q = (as * 65536) / ac;
    return neg ? -q : q;
  endfunction

  function automatic vnext_t euler_step(vstate_t v);
    vnext_t n;
    longint dt, sp, c, s, dx, dy, rate, dyaw;
    dt = longint'(dt_q);
    sp = longint'(v.sp);
    sin_cos(longint'(v.hd), c, s);
    dx = round_shr(sp * c, 30);
    dy = round_shr(sp * s, 30);
    rate = round_shr(sp * longint'(iwb_q), 16);
    dyaw = round_shr(rate * steer_tan(longint'(v.st)), 16);
    n.px = 32'(clamp32(longint'(v.px) + round_shr(dx * dt, 16)));
    n.py = 32'(clamp32(longint'(v.py) + round_shr(dy * dt, 16)));
    n.hd = 32'(clamp32(longint'(v.hd) + round_shr(dyaw * dt, 16)));
    n.sp = 32'(clamp32(sp + round_shr(longint'(v.ac) * dt, 16)));
    return n;
  endfunction

  task automatic send_state(vstate_t v);
    int gap;
    gap = idle_en ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= v.px; pos_y <= v.py; heading <= v.hd;
    speed <= v.sp; steer_angle <= v.st; accel <= v.ac;
    do @(posedge clk); while (in_stall);
    next_state_q.push_back(euler_step(v));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (next_state_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TIME_STEP) dt_q = data[TS_W-1:0];
    else if (idx == CFG_INV_WHEEL_BASE) iwb_q = data[IWB_W-1:0];
  endtask

  function automatic logic signed [17:0] rand_steer();
    if ($urandom_range(0, 9) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 2 * STEER_MAX)) - STEER_MAX);
  endfunction

  function automatic vstate_t rand_state();
    vstate_t v;
    v.px = $urandom; v.py = $urandom; v.hd = $urandom; v.sp = $urandom; v.ac = $urandom;
    if ($urandom_range(0, 2) != 0) begin
      v.hd = $signed(v.hd) >>> $urandom_range(8, 14);
      v.sp = $signed(v.sp) >>> $urandom_range(4, 14);
      v.ac = $signed(v.ac) >>> $urandom_range(4, 16);
    end
    v.st = rand_steer();
    return v;
  endfunction

  function automatic vstate_t mk(logic signed [31:0] px, py, hd, sp,
                                 logic signed [17:0] st, logic signed [31:0] ac);
    vstate_t v;
    v.px = px; v.py = py; v.hd = hd; v.sp = sp; v.st = st; v.ac = ac;
    return v;
  endfunction

  task automatic test_directed();
    send_state(mk(0, 0, 0, 0, 0, 0));
    send_state(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  18'sd102944, 32'sh7FFFFFFF));
    send_state(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  -18'sd102944, 32'sh80000000));
    send_state(mk(32'sh7FFF0000, 0, 0, 32'sh7FFFFFFF, 0, 0));
    send_state(mk(0, 32'sh80000000, -32'sd102944, 32'sh7FFFFFFF, 0, 0));
    send_state(mk(0, 0, 32'sd102944, 32'sd655360, 18'sd102943, 32'sd65536));
    send_state(mk(0, 0, 32'sd205887, 32'sd655360, -18'sd102943, -32'sd65536));
    send_state(mk(0, 0, -32'sd205887, 32'sd655360, 18'sd102900, 0));
    send_state(mk(0, 0, 32'sd51472, -32'sd655360, 18'sh1FFFF, 0));
    send_state(mk(0, 0, 32'sd411775, 32'sd655360, 18'sh20000, 0));
    send_state(mk(32'sd12345, -32'sd777, 32'sd1000000000, 32'sd3276800, 18'sd110000, 0));
    send_state(mk(1, -1, -32'sd1000000000, -32'sd3276800, -18'sd110000, 32'sd1));
    send_state(mk(0, 0, 32'sd25736, 32'sd65536, 18'sd25736, -32'sd1));
    send_state(mk(32'sh55555555, 32'shAAAAAAAA, 32'sh0000AAAA, 32'sh00055555,
                  18'sh15555, 32'shAAAAAAAA));
    send_state(mk(32'shAAAAAAAA, 32'sh55555555, 32'shFFFF5555, 32'shFFFAAAAA,
                  18'sh2AAAA, 32'sh55555555));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) idle_en = ($urandom_range(0, 3) != 0);
      send_state(rand_state());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_TIME_STEP, 20'd0);
    write_reg(CFG_INV_WHEEL_BASE, 20'd1);
    test_random(40);
    write_reg(CFG_TIME_STEP, 20'd65536);
    write_reg(CFG_INV_WHEEL_BASE, 20'd655360);
    test_directed();
    test_random(60);
    write_reg(CFG_TIME_STEP, 20'hFFFFF);
    write_reg(CFG_INV_WHEEL_BASE, 20'hFFFFF);
    test_random(40);
    write_reg(CFG_INV_WHEEL_BASE, 20'd0);
    write_reg(CFG_SPARE_A, 20'h5A5A5);
    write_reg(CFG_SPARE_B, 20'hFFFFF);
    test_random(30);
    write_reg(CFG_TIME_STEP, 20'($urandom));
    write_reg(CFG_INV_WHEEL_BASE, 20'($urandom_range(1, 655360)));
    test_random(40);
    write_reg(CFG_TIME_STEP, 20'(TIME_STEP_RST));
    write_reg(CFG_INV_WHEEL_BASE, 20'(IWB_RST));
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req = 1'b1;
    test_random(150);
    idle_en = 1'b1;
  endtask

  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = idle_en ? $urandom_range(0, 17) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid || rst);
      if (next_state_q.size() == 0) begin
        $display("%0t: result with nothing pending: %h %h %h %h", $time,
                 new_pos_x, new_pos_y, new_heading, new_speed);
        errors++;
      end else begin
        vnext_t e;
        e = next_state_q.pop_front();
        if (new_pos_x !== e.px) begin
          $display("%0t: new_pos_x exp %h got %h", $time, e.px, new_pos_x); errors++;
        end
        if (new_pos_y !== e.py) begin
          $display("%0t: new_pos_y exp %h got %h", $time, e.py, new_pos_y); errors++;
        end
        if (new_heading !== e.hd) begin
          $display("%0t: new_heading exp %h got %h", $time, e.hd, new_heading); errors++;
        end
        if (new_speed !== e.sp) begin
          $display("%0t: new_speed exp %h got %h", $time, e.sp, new_speed); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_config_sweep();
    test_backpressure();
    test_random(720);
    wait_drained();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
